/* rtl/tri_pkg.sv */
// Shared types and constants for the toon ramp interpolator.
// No dependencies; every rtl module imports this package.
`default_nettype none

package tri_pkg;

  localparam int NUM_STOPS      = 4;
  localparam int Q12_BITS       = 13;
  localparam int FRAC_BITS      = 12;
  localparam int DIV_BITS       = 15;
  localparam int BITS_PER_STAGE = 3;
  localparam int DIV_STAGES     = DIV_BITS / BITS_PER_STAGE;

  localparam logic [12:0] Q12_ONE  = 13'd4096;
  localparam logic [12:0] MIN_SPAN = 13'd4;

  // Configuration register indexes
  localparam logic [2:0] REG_STOP_COUNT = 3'd0;
  localparam logic [2:0] REG_STOP_0     = 3'd1;
  localparam logic [2:0] REG_STOP_1     = 3'd2;
  localparam logic [2:0] REG_STOP_2     = 3'd3;
  localparam logic [2:0] REG_STOP_3     = 3'd4;

  typedef logic [Q12_BITS-1:0] q12_t;

  // Payload that travels through the divider stages
  typedef struct packed {
    logic               valid;
    logic               direct;     // bypass value is the result
    logic signed [15:0] direct_val;
    logic               neg;        // quotient is negative
    logic               ovf;        // quotient magnitude beyond 15 bits
    q12_t               span;       // divisor
    q12_t               rem;        // partial remainder
    logic [DIV_BITS-1:0] dvd;       // dividend bits still to shift in
    logic [DIV_BITS-1:0] quo;       // quotient bits so far
    q12_t               red_p;      // red level of the previous stop
    logic signed [13:0] red_diff;   // red of found stop minus red_p
  } tri_div_t;

endpackage

`default_nettype wire

/* rtl/tri_select.sv */
// Front end: clamp, stop search, span and dividend setup (two stages).
// Depends on tri_pkg.
`default_nettype none

module tri_select import tri_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic signed [15:0] light_term,
  input  logic [2:0]         stop_count,
  input  q12_t               thr [NUM_STOPS],
  input  q12_t               red [NUM_STOPS],
  output tri_div_t           div_out
);

  // Stage 1 registers
  logic               s1_valid;
  logic signed [15:0] s1_raw;
  q12_t               s1_x;
  logic [2:0]         s1_n;
  logic [NUM_STOPS-1:0] s1_hit;

  logic [2:0]           n_lim;
  q12_t                 x_clamp;
  logic [NUM_STOPS-1:0] hit;

  always_comb begin
    n_lim = (stop_count > 3'(NUM_STOPS)) ? 3'(NUM_STOPS) : stop_count;
    if (light_term < 16'sd0) begin
      x_clamp = '0;
    end else if (light_term > $signed({3'b000, Q12_ONE})) begin
      x_clamp = Q12_ONE;
    end else begin
      x_clamp = light_term[12:0];
    end
    hit[0] = 1'b0;
    for (int k = 1; k < NUM_STOPS; k++) begin
      hit[k] = (3'(k) < n_lim) && (x_clamp <= thr[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
    s1_raw <= light_term;
    s1_x   <= x_clamp;
    s1_n   <= n_lim;
    s1_hit <= hit;
  end

  // Stage 2: pick the first qualifying stop and set up the division
  logic [1:0]         sel;
  logic [1:0]         prev;
  logic [1:0]         last;
  logic               found;
  logic signed [13:0] diff;
  logic signed [13:0] span_raw;
  q12_t               dmag;
  q12_t               span;
  tri_div_t           div_next;

  always_comb begin
    sel   = '0;
    found = 1'b0;
    for (int k = NUM_STOPS - 1; k >= 1; k--) begin
      if (s1_hit[k]) begin
        sel   = 2'(k);
        found = 1'b1;
      end
    end
    prev     = sel - 2'd1;
    last     = 2'(s1_n - 3'd1);
    diff     = $signed({1'b0, s1_x}) - $signed({1'b0, thr[prev]});
    span_raw = $signed({1'b0, thr[sel]}) - $signed({1'b0, thr[prev]});
    span     = (span_raw < $signed({1'b0, MIN_SPAN})) ? MIN_SPAN : span_raw[12:0];
    dmag     = diff[13] ? 13'(-diff) : diff[12:0];

    div_next.valid    = s1_valid;
    div_next.direct   = (s1_n == 3'd0) || !found;
    div_next.direct_val = (s1_n == 3'd0) ? s1_raw : $signed({3'b000, red[last]});
    div_next.neg      = diff[13];
    // Dividend is dmag << 12; its top ten bits decide overflow of a 15-bit quotient
    div_next.ovf      = ({3'b000, dmag[12:3]} >= span);
    div_next.span     = span;
    div_next.rem      = div_next.ovf ? '0 : {3'b000, dmag[12:3]};
    div_next.dvd      = {dmag[2:0], 12'd0};
    div_next.quo      = '0;
    div_next.red_p    = red[prev];
    div_next.red_diff = $signed({1'b0, red[sel]}) - $signed({1'b0, red[prev]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_out.valid <= 1'b0;
    end else begin
      div_out.valid <= div_next.valid;
    end
    div_out.direct     <= div_next.direct;
    div_out.direct_val <= div_next.direct_val;
    div_out.neg        <= div_next.neg;
    div_out.ovf        <= div_next.ovf;
    div_out.span       <= div_next.span;
    div_out.rem        <= div_next.rem;
    div_out.dvd        <= div_next.dvd;
    div_out.quo        <= div_next.quo;
    div_out.red_p      <= div_next.red_p;
    div_out.red_diff   <= div_next.red_diff;
  end

endmodule

`default_nettype wire

/* rtl/tri_div_stage.sv */
// One stage of the restoring divider: retires BITS_PER_STAGE quotient bits.
// Depends on tri_pkg.
`default_nettype none

module tri_div_stage import tri_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  tri_div_t div_in,
  output tri_div_t div_out
);

  tri_div_t      div_next;
  logic [13:0]   trial;

  always_comb begin
    div_next = div_in;
    trial    = '0;
    for (int k = 0; k < BITS_PER_STAGE; k++) begin
      trial        = {div_next.rem, div_next.dvd[DIV_BITS-1]};
      div_next.dvd = {div_next.dvd[DIV_BITS-2:0], 1'b0};
      if (trial >= {1'b0, div_next.span}) begin
        div_next.rem = 13'(trial - {1'b0, div_next.span});
        div_next.quo = {div_next.quo[DIV_BITS-2:0], 1'b1};
      end else begin
        div_next.rem = trial[12:0];
        div_next.quo = {div_next.quo[DIV_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_out.valid <= 1'b0;
    end else begin
      div_out.valid <= div_next.valid;
    end
    div_out.direct     <= div_next.direct;
    div_out.direct_val <= div_next.direct_val;
    div_out.neg        <= div_next.neg;
    div_out.ovf        <= div_next.ovf;
    div_out.span       <= div_next.span;
    div_out.rem        <= div_next.rem;
    div_out.dvd        <= div_next.dvd;
    div_out.quo        <= div_next.quo;
    div_out.red_p      <= div_next.red_p;
    div_out.red_diff   <= div_next.red_diff;
  end

endmodule

`default_nettype wire

/* rtl/tri_blend.sv */
// Back end: form the saturated weight, multiply, add base, floor and saturate.
// Depends on tri_pkg.
`default_nettype none

module tri_blend import tri_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  tri_div_t           div_in,
  output logic               done,
  output logic signed [15:0] shade
);

  // Multiply stage registers
  logic               m_valid;
  logic               m_direct;
  logic signed [15:0] m_direct_val;
  logic signed [29:0] m_prod;
  q12_t               m_red_p;

  logic signed [15:0] weight;

  always_comb begin
    if (div_in.ovf) begin
      weight = div_in.neg ? 16'sh8000 : 16'sh7FFF;
    end else if (div_in.neg) begin
      weight = -$signed({1'b0, div_in.quo});
    end else begin
      weight = $signed({1'b0, div_in.quo});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else begin
      m_valid <= div_in.valid;
    end
    m_direct     <= div_in.direct;
    m_direct_val <= div_in.direct_val;
    m_prod       <= 30'(div_in.red_diff * weight);
    m_red_p      <= div_in.red_p;
  end

  // Final stage: red_p * 4096 + prod, floor by 4096, saturate
  logic signed [30:0] acc;
  logic signed [18:0] scaled;
  logic signed [15:0] shade_next;

  always_comb begin
    acc    = 31'(m_prod) + $signed({6'd0, m_red_p, 12'd0});
    scaled = 19'(acc >>> FRAC_BITS);
    if (m_direct) begin
      shade_next = m_direct_val;
    end else if (scaled > 19'sd32767) begin
      shade_next = 16'sh7FFF;
    end else if (scaled < -19'sd32768) begin
      shade_next = 16'sh8000;
    end else begin
      shade_next = scaled[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= m_valid;
    end
    shade <= shade_next;
  end

endmodule

`default_nettype wire

/* rtl/toon_ramp_interpolator_core.sv */
// Top level of the toon ramp interpolator: configuration registers and pipeline.
// Depends on tri_pkg, tri_select, tri_div_stage, tri_blend.
//
//   channel   ports                          direction  notes
//   ------    -----------------------------  ---------  ------------------------------
//   command   start, busy, light_term        in / out   taken when start && !busy
//   result    done, shade                    out        one-cycle strobe, no backpressure
//   config    cfg_we, cfg_index, cfg_data    in         write only, takes effect next edge
//
// A transaction enters every cycle; busy is tied low. The pipeline has
// two front-end stages (clamp and stop search, then span setup), five divider
// stages of three quotient bits each, a multiply stage and a final add/saturate
// stage. The divider stages set the depth. Reset is synchronous and clears valid
// bits and the configuration registers to their documented defaults; payload
// registers are not reset. The receiver cannot stall, so the pipeline never holds.
`default_nettype none

module toon_ramp_interpolator_core import tri_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] light_term,
  output logic               done,
  output logic signed [15:0] shade,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [28:0]        cfg_data
);

  logic [2:0] stop_count;
  q12_t       thr [NUM_STOPS];
  q12_t       red [NUM_STOPS];

  // Pipeline never backs up
  assign busy = 1'b0;

  // Configuration writes; indexes past the last stop drop silently
  always_ff @(posedge clk) begin
    if (rst) begin
      stop_count <= 3'd4;
      red[0] <= 13'h0C00;  thr[0] <= 13'h0000;
      red[1] <= 13'h0EB8;  thr[1] <= 13'h059A;
      red[2] <= 13'h0FAE;  thr[2] <= 13'h0A66;
      red[3] <= 13'h1000;  thr[3] <= 13'h1000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STOP_COUNT: begin
          stop_count <= cfg_data[2:0];
        end
        REG_STOP_0: begin
          thr[0] <= cfg_data[12:0];
          red[0] <= cfg_data[28:16];
        end
        REG_STOP_1: begin
          thr[1] <= cfg_data[12:0];
          red[1] <= cfg_data[28:16];
        end
        REG_STOP_2: begin
          thr[2] <= cfg_data[12:0];
          red[2] <= cfg_data[28:16];
        end
        REG_STOP_3: begin
          thr[3] <= cfg_data[12:0];
          red[3] <= cfg_data[28:16];
        end
        default: begin
        end
      endcase
    end
  end

  tri_div_t div_chain [DIV_STAGES+1];

  // Clamp, stop search and division setup
  tri_select u_select (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (start && !busy),
    .light_term (light_term),
    .stop_count (stop_count),
    .thr        (thr),
    .red        (red),
    .div_out    (div_chain[0])
  );

  // Quotient bits, most significant first
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    tri_div_stage u_div (
      .clk     (clk),
      .rst     (rst),
      .div_in  (div_chain[g]),
      .div_out (div_chain[g+1])
    );
  end

  // Weight, multiply, floor and saturate
  tri_blend u_blend (
    .clk    (clk),
    .rst    (rst),
    .div_in (div_chain[DIV_STAGES]),
    .done   (done),
    .shade  (shade)
  );

endmodule

`default_nettype wire
